// ===== design/irm_pkg.sv =====
`default_nettype none

package irm_pkg;

  // request and result field widths
  localparam int START_W  = 10;
  localparam int END_W    = 11;
  localparam int STATUS_W = 2;

  // bitmap word geometry
  localparam int WORD_SH = 5;
  localparam int WORD_W  = 1 << WORD_SH;

  // default map size
  localparam int DEFAULT_SLOTS = 1024;

  typedef logic [START_W-1:0]  start_t;
  typedef logic [END_W-1:0]    end_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [WORD_SH-1:0]  bit_idx_t;

  // result codes
  localparam status_t STATUS_BOOKED  = 2'd0;
  localparam status_t STATUS_OVERLAP = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;

endpackage

`default_nettype wire

// ===== design/irm_if.sv =====
`default_nettype none

// request channel
interface irm_req_if;
  import irm_pkg::*;

  logic   valid;
  logic   ready;
  start_t start_slot;
  end_t   end_slot;

  modport source (output valid, output start_slot, output end_slot, input ready);
  modport sink (input valid, input start_slot, input end_slot, output ready);
endinterface

// result channel
interface irm_rsp_if;
  import irm_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

// ===== design/irm_word_ram.sv =====
`default_nettype none

module irm_word_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/interval_reservation_map.sv =====
// operation: an invalid range is answered without touching the map; a valid range scans then sets
//   the n bitmap words it touches, one word per cycle through the registered ram read
//   (n up to 32 at the default size)
// throughput: one request at a time; the next request is taken once the result is queued
// reset: synchronous, clears control state and the per-word valid bits, so the
//   whole map reads as free right after reset; no clearing pass
`default_nettype none

module interval_reservation_map #(
  parameter int SLOTS = irm_pkg::DEFAULT_SLOTS
) (
  input wire logic clk,
  input wire logic rst,
  irm_req_if.sink   req,
  irm_rsp_if.source rsp
);

  import irm_pkg::*;

  // only slots below the largest end value can ever be touched
  localparam int MAX_END   = (1 << END_W) - 1;
  localparam int MAP_SLOTS = (SLOTS < MAX_END) ? SLOTS : MAX_END;
  localparam int WORDS     = (MAP_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SET  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [WA_W-1:0] first_word;
  logic [WA_W-1:0] last_word;
  bit_idx_t        lo_bit;
  bit_idx_t        hi_bit;
  status_t         result;
  status_t         result_next;

  logic [WA_W-1:0] rd_addr;
  logic [WA_W-1:0] rd_addr_next;
  logic            issuing;
  logic            issuing_next;
  logic            rd_live;
  logic            rd_live_next;
  logic [WA_W-1:0] chk_addr;
  logic [WA_W-1:0] chk_addr_next;
  logic [WORDS-1:0] word_valid;

  logic            req_xfer;
  end_t            last_slot;
  logic            range_bad;
  logic            out_free;

  logic            ram_we;
  word_t           ram_rdata;
  word_t           cur_word;
  word_t           cur_mask;
  bit_idx_t        mask_lo;
  bit_idx_t        mask_hi;
  logic            hit;
  logic            at_last;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign last_slot = END_W'(req.end_slot - 1'b1);
  assign range_bad = (req.end_slot <= END_W'(req.start_slot)) ||
                     (req.end_slot > END_W'(MAP_SLOTS));
  assign out_free  = !rsp.valid || rsp.ready;

  // bitmap word store
  irm_word_ram #(
    .DEPTH  (WORDS),
    .ADDR_W (WA_W),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_addr),
    .wdata (cur_word | cur_mask),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // range bits that fall inside the word being checked
  always_comb begin
    mask_lo  = (chk_addr == first_word) ? lo_bit : '0;
    mask_hi  = (chk_addr == last_word) ? hi_bit : bit_idx_t'(WORD_W - 1);
    cur_mask = ({WORD_W{1'b1}} << mask_lo) &
               ({WORD_W{1'b1}} >> (bit_idx_t'(WORD_W - 1) - mask_hi));
    cur_word = word_valid[chk_addr] ? ram_rdata : '0;
    hit      = |(cur_word & cur_mask);
    at_last  = (chk_addr == last_word);
    ram_we   = (state == S_SET) && rd_live;
  end

  // sequencer: issue reads one word per cycle, check or update each word in the next cycle
  always_comb begin
    state_next    = state;
    result_next   = result;
    rd_addr_next  = rd_addr;
    issuing_next  = issuing;
    rd_live_next  = 1'b0;
    chk_addr_next = chk_addr;

    if ((state == S_SCAN || state == S_SET) && issuing) begin
      rd_live_next  = 1'b1;
      chk_addr_next = rd_addr;
      if (rd_addr == last_word) begin
        issuing_next = 1'b0;
      end else begin
        rd_addr_next = WA_W'(rd_addr + 1'b1);
      end
    end

    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          rd_addr_next = WA_W'(req.start_slot[START_W-1:WORD_SH]);
          issuing_next = !range_bad;
          if (range_bad) begin
            result_next = STATUS_INVALID;
            state_next  = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_live) begin
          if (hit) begin
            result_next  = STATUS_OVERLAP;
            state_next   = S_FIN;
            issuing_next = 1'b0;
            rd_live_next = 1'b0;
          end else if (at_last) begin
            state_next   = S_SET;
            rd_addr_next = first_word;
            issuing_next = 1'b1;
            rd_live_next = 1'b0;
          end
        end
      end
      S_SET: begin
        if (rd_live && at_last) begin
          result_next = STATUS_BOOKED;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issuing    <= 1'b0;
      rd_live    <= 1'b0;
      word_valid <= '0;
    end else begin
      state   <= state_next;
      issuing <= issuing_next;
      rd_live <= rd_live_next;
      if (ram_we) begin
        word_valid[chk_addr] <= 1'b1;
      end
    end
  end

  // request payload and pipeline addresses
  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    chk_addr <= chk_addr_next;
    result   <= result_next;
    if (req_xfer) begin
      first_word <= WA_W'(req.start_slot[START_W-1:WORD_SH]);
      last_word  <= WA_W'(last_slot[END_W-1:WORD_SH]);
      lo_bit     <= req.start_slot[WORD_SH-1:0];
      hi_bit     <= last_slot[WORD_SH-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      rsp.status <= result;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import irm_pkg::*;

  localparam int SLOTS       = DEFAULT_SLOTS;
  localparam int RAND_REQS   = 530;
  localparam int CALM_TAIL   = 50;
  localparam int DRAIN_WAIT  = 80;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    start_t first;
    end_t   past;
  } slot_req_t;

  logic clk;
  logic rst;

  irm_req_if req_ch ();
  irm_rsp_if rsp_ch ();

  interval_reservation_map #(.SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_req_t pending_reqs[$];
  status_t   expected_status[$];
  bit [SLOTS-1:0] slot_taken;
  bit [SLOTS-1:0] plan_taken;
  int mismatches;
  int req_gap;
  int rsp_gap;
  int stall_cycles;

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // occupancy update for one request, returns the status it earns
  function automatic status_t reserve_range(ref bit [SLOTS-1:0] taken, input int first,
                                            input int past);
    int i;
    if (past <= first || past > SLOTS) return STATUS_INVALID;
    for (i = first; i < past; i++) begin
      if (taken[i]) return STATUS_OVERLAP;
    end
    for (i = first; i < past; i++) taken[i] = 1'b1;
    return STATUS_BOOKED;
  endfunction

  // queue one request, tracking a planning copy of the map to steer stimulus
  task automatic queue_req(int first, int past);
    slot_req_t r;
    r.first = start_t'(first);
    r.past  = end_t'(past);
    pending_reqs.push_back(r);
    void'(reserve_range(plan_taken, first, past));
  endtask

  // request driver, predicts on every transfer
  always @(posedge clk) begin : drive_req
    logic      next_valid;
    slot_req_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else begin
      next_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_status.push_back(reserve_range(slot_taken, int'(req_ch.start_slot),
                                                int'(req_ch.end_slot)));
        next_valid = 1'b0;
        if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
          req_gap = $urandom_range(1, 5);
      end
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          req_ch.start_slot <= r.first;
          req_ch.end_slot   <= r.past;
          next_valid = 1'b1;
        end
      end
      req_ch.valid <= next_valid;
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin : watch_rsp
    status_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_status.size() == 0) begin
          $error("status: expected none, got %0d", rsp_ch.status);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (rsp_ch.status !== want) begin
            $error("status: expected %0d, got %0d", want, rsp_ch.status);
            mismatches++;
          end
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          rsp_gap = $urandom_range(1, 5);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("interval_reservation_map verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    int roll;
    int s;
    int e;
    int len;
    int k;
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.start_slot = '0;
    req_ch.end_slot   = '0;
    rsp_ch.ready      = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    slot_taken   = '0;
    plan_taken   = '0;

    // empty and out-of-map ranges
    queue_req(5, 5);
    queue_req(0, 0);
    queue_req(9, 3);
    queue_req(SLOTS - 1, SLOTS - 1);
    queue_req(0, SLOTS + 1);
    queue_req(SLOTS - 1, 2047);
    // adjacency is not overlap, a range straddling the shared edge is
    queue_req(10, 20);
    queue_req(20, 30);
    queue_req(19, 21);
    queue_req(9, 10);
    queue_req(0, 1);
    // map edges
    queue_req(SLOTS - 1, SLOTS);
    queue_req(1000, SLOTS);
    queue_req(0, SLOTS);
    // word boundaries and multi-word ranges
    queue_req(31, 33);
    queue_req(64, 96);
    queue_req(63, 64);
    queue_req(96, 97);
    queue_req(80, 81);
    queue_req(200, 520);
    queue_req(100, 1000);
    queue_req(1, 9);
    queue_req(600, 601);

    // random part: mostly ranges aimed at holes, some overlaps and invalid ones
    for (n = 0; n < RAND_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        s = $urandom_range(0, SLOTS - 1);
        e = $urandom_range(0, s);
      end else if (pick < 14) begin
        s = $urandom_range(0, SLOTS - 1);
        e = $urandom_range(SLOTS + 1, 2047);
      end else begin
        s = $urandom_range(0, SLOTS - 1);
        if (pick < 70) begin
          for (k = 0; k < SLOTS && plan_taken[(s + k) % SLOTS]; k++) ;
          if (k < SLOTS) s = (s + k) % SLOTS;
        end
        roll = $urandom_range(0, 9);
        if (roll < 7) len = $urandom_range(1, 4);
        else if (roll < 9) len = $urandom_range(5, 32);
        else len = $urandom_range(33, SLOTS);
        e = (s + len > SLOTS) ? SLOTS : s + len;
      end
      queue_req(s, e);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // drain
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_status.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("interval_reservation_map verification clean");
    end else begin
      $display("interval_reservation_map verification failed");
    end
    $finish;
  end

endmodule
